>>> design/dtbp_pkg.sv
// shared types, codes and widths of the dual token bucket policer
package dtbp_pkg;

   localparam int RATE_W  = 32;
   localparam int TIME_W  = 32;
   localparam int SIZE_W  = 16;
   localparam int LEVEL_W = 29;
   localparam int COUNT_W = 48;
   localparam int STATE_W = 2;
   localparam int INDEX_W = 2;
   localparam int PROD_W  = TIME_W + RATE_W;

   // item kinds
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_PACKET = 1'b1;

   // send state codes
   localparam logic [STATE_W-1:0] ST_CAN_SEND   = 2'd0;
   localparam logic [STATE_W-1:0] ST_CANT_SEND  = 2'd1;
   localparam logic [STATE_W-1:0] ST_MAY_BORROW = 2'd2;

   // register indexes
   localparam logic [INDEX_W-1:0] CSR_RATE         = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_CEILING_RATE = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_START_TIME   = 2'd2;

   typedef struct packed {
      logic              func;
      logic [TIME_W-1:0] now;
      logic [SIZE_W-1:0] pkt_len;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               borrowed;
      logic [STATE_W-1:0] class_state;
      logic [LEVEL_W-1:0] tokens_left;
      logic [LEVEL_W-1:0] ceiling_tokens_left;
      logic [COUNT_W-1:0] bytes_total;
      logic [COUNT_W-1:0] packets_total;
      logic [COUNT_W-1:0] drop_total;
      logic [COUNT_W-1:0] overlimit_total;
   } rsp_type;

endpackage

>>> design/dual_token_bucket_policer_unit.sv
// Dual-rate token bucket policer for one traffic class. Each item passes
// through an input register and a result register with all of its work
// (one 32x32 refill multiply per bucket, then add, cap, compare and charge)
// done combinationally between them. One item is taken every cycle unless a
// result waits on rsp_stall with the input register full; the result register
// loads as the item leaves the input register, which holds one more item while
// a result waits on rsp_stall. The user must write registers through the csr_
// port only while no item is in flight; the block does not enforce it. Writing
// start_time refills both buckets to their current caps.
module dual_token_bucket_policer_unit
   import dtbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_write_en,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [RATE_W-1:0]  csr_data
);

   logic               in_valid_ff, in_valid_in;
   req_type            in_data_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_data_ff, out_data_in;

   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [RATE_W-1:0]  ceil_rate_ff, ceil_rate_in;
   logic [LEVEL_W-1:0] g_level_ff, g_level_in;
   logic [LEVEL_W-1:0] c_level_ff, c_level_in;
   logic [TIME_W-1:0]  last_time_ff, last_time_in;
   logic [STATE_W-1:0] send_state_ff, send_state_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;
   logic [COUNT_W-1:0] packets_ff, packets_in;
   logic [COUNT_W-1:0] drops_ff, drops_in;
   logic [COUNT_W-1:0] overlimit_ff, overlimit_in;

   logic               advance, take, fire;
   logic [TIME_W-1:0]  elapsed;
   logic [LEVEL_W-1:0] g_refill, c_refill;
   logic [LEVEL_W-1:0] size_ext;
   logic               accepted, borrowed;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign fire      = in_valid_ff && advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign elapsed  = in_data_ff.now - last_time_ff;
   assign size_ext = LEVEL_W'(in_data_ff.pkt_len);

   dtbp_refill u_refill_g (
      .level     (g_level_ff),
      .elapsed   (elapsed),
      .per_unit  (rate_ff),
      .level_new (g_refill)
   );

   dtbp_refill u_refill_c (
      .level     (c_level_ff),
      .elapsed   (elapsed),
      .per_unit  (ceil_rate_ff),
      .level_new (c_refill)
   );

   always_comb begin
      in_valid_in   = take || (in_valid_ff && !fire);
      out_valid_in  = fire || (out_valid_ff && rsp_stall);
      rate_in       = rate_ff;
      ceil_rate_in  = ceil_rate_ff;
      g_level_in    = g_level_ff;
      c_level_in    = c_level_ff;
      last_time_in  = last_time_ff;
      send_state_in = send_state_ff;
      bytes_in      = bytes_ff;
      packets_in    = packets_ff;
      drops_in      = drops_ff;
      overlimit_in  = overlimit_ff;
      accepted      = 1'b0;
      borrowed      = 1'b0;

      if (fire) begin
         if (in_data_ff.func == FUNC_TICK) begin
            g_level_in   = g_refill;
            c_level_in   = c_refill;
            last_time_in = in_data_ff.now;
         end else begin
            if (g_level_ff >= size_ext) begin
               g_level_in = g_level_ff - size_ext;
               accepted   = 1'b1;
            end else if (send_state_ff == ST_MAY_BORROW && c_level_ff >= size_ext) begin
               c_level_in   = c_level_ff - size_ext;
               accepted     = 1'b1;
               borrowed     = 1'b1;
               overlimit_in = overlimit_ff + COUNT_W'(1);
            end else begin
               drops_in = drops_ff + COUNT_W'(1);
            end
            if (accepted) begin
               bytes_in   = bytes_ff + COUNT_W'(in_data_ff.pkt_len);
               packets_in = packets_ff + COUNT_W'(1);
            end
            // state left for the next packet
            if (g_level_in != '0) begin
               send_state_in = ST_CAN_SEND;
            end else if (c_level_in != '0) begin
               send_state_in = ST_MAY_BORROW;
            end else begin
               send_state_in = ST_CANT_SEND;
            end
         end
      end

      if (csr_write_en) begin
         case (csr_index)
            CSR_RATE:         rate_in = csr_data;
            CSR_CEILING_RATE: ceil_rate_in = csr_data;
            CSR_START_TIME: begin
               last_time_in = csr_data;
               g_level_in   = rate_ff[RATE_W-1:3];
               c_level_in   = ceil_rate_ff[RATE_W-1:3];
            end
            default: ;
         endcase
      end

      out_data_in.accepted            = accepted;
      out_data_in.borrowed            = borrowed;
      out_data_in.class_state         = send_state_in;
      out_data_in.tokens_left         = g_level_in;
      out_data_in.ceiling_tokens_left = c_level_in;
      out_data_in.bytes_total         = bytes_in;
      out_data_in.packets_total       = packets_in;
      out_data_in.drop_total          = drops_in;
      out_data_in.overlimit_total     = overlimit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         rate_ff       <= '0;
         ceil_rate_ff  <= '0;
         g_level_ff    <= '0;
         c_level_ff    <= '0;
         last_time_ff  <= '0;
         send_state_ff <= ST_CAN_SEND;
         bytes_ff      <= '0;
         packets_ff    <= '0;
         drops_ff      <= '0;
         overlimit_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         rate_ff       <= rate_in;
         ceil_rate_ff  <= ceil_rate_in;
         g_level_ff    <= g_level_in;
         c_level_ff    <= c_level_in;
         last_time_ff  <= last_time_in;
         send_state_ff <= send_state_in;
         bytes_ff      <= bytes_in;
         packets_ff    <= packets_in;
         drops_ff      <= drops_in;
         overlimit_ff  <= overlimit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

>>> design/dtbp_refill.sv
// bucket refill: level plus elapsed time times rate, saturated at rate/8
module dtbp_refill
   import dtbp_pkg::*;
(
   input  logic [LEVEL_W-1:0] level,
   input  logic [TIME_W-1:0]  elapsed,
   input  logic [RATE_W-1:0]  per_unit,
   output logic [LEVEL_W-1:0] level_new
);

   logic [LEVEL_W-1:0] cap;
   logic [PROD_W-1:0]  product;
   logic [PROD_W:0]    sum;

   always_comb begin
      cap       = per_unit[RATE_W-1:3];
      product   = PROD_W'(elapsed) * PROD_W'(per_unit);
      sum       = {1'b0, product} + (PROD_W + 1)'(level);
      level_new = (sum > (PROD_W + 1)'(cap)) ? cap : sum[LEVEL_W-1:0];
   end

endmodule

>>> design/dtbp_checker.sv
// port-level checks for the policer, bound to the top level
module dtbp_checker
   import dtbp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // borrowing only ever sends a packet
   a_borrow_sends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.borrowed |-> rsp_data.accepted)
      else $error("borrowed item not accepted");

   // an empty result register never back-pressures the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipe not empty after reset");

endmodule

bind dual_token_bucket_policer_unit dtbp_checker u_dtbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
